[hw/rtl/lrpc_pkg.sv]
// shared types, constants and arithmetic helpers of the lidar range to point converter
package lrpc_pkg;

    localparam int RANGE_W  = 16;
    localparam int COLUMN_W = 12;
    localparam int ROW_W    = 6;
    localparam int ANGLE_W  = 16;
    localparam int TRIG_W   = 16;
    localparam int COORD_W  = 17;
    localparam int CORD_W   = 33;
    localparam int MASK_W   = 64;

    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    localparam int CORDIC_STAGES = 16;
    localparam int CORDIC_PAIRS  = CORDIC_STAGES / 2;
    localparam int CORDIC_LAT    = CORDIC_PAIRS + 2;

    localparam logic signed [CORD_W-1:0] CORDIC_X0 = 33'sd652032874;

    localparam logic signed [CORD_W-1:0] ATAN_TURNS [CORDIC_STAGES] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
        33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
        33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
        33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861
    };

    localparam logic [2:0] REG_RANGE_LO    = 3'd0;
    localparam logic [2:0] REG_RANGE_HI    = 3'd1;
    localparam logic [2:0] REG_YAW_START   = 3'd2;
    localparam logic [2:0] REG_YAW_STEP    = 3'd3;
    localparam logic [2:0] REG_PITCH_START = 3'd4;
    localparam logic [2:0] REG_PITCH_STEP  = 3'd5;
    localparam logic [2:0] REG_ROW_MASK    = 3'd6;

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [CORD_W-1:0] z;
    } t_cordic_vec;

    function automatic t_cordic_vec cordic_rotate(input t_cordic_vec v, input logic [3:0] k);
        t_cordic_vec r;
        logic signed [CORD_W-1:0] dx;
        logic signed [CORD_W-1:0] dy;
        dx = $signed(v.y) >>> k;
        dy = $signed(v.x) >>> k;
        if (!v.z[CORD_W-1]) begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - ATAN_TURNS[k];
        end else begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + ATAN_TURNS[k];
        end
        return r;
    endfunction

    // scale 2^30 to 2^15, half away from zero, saturated
    function automatic logic signed [TRIG_W-1:0] round_trig(input logic signed [CORD_W-1:0] v);
        logic signed [CORD_W:0] ve;
        logic [CORD_W:0]        mag;
        logic [18:0]            q;
        logic signed [TRIG_W-1:0] sat;
        ve  = (CORD_W+1)'(v);
        mag = ve[CORD_W] ? (CORD_W+1)'(-ve) : (CORD_W+1)'(ve);
        q   = 19'((mag + 34'd16384) >> 15);
        sat = (q > 19'd32767) ? 16'sd32767 : $signed(q[15:0]);
        return v[CORD_W-1] ? -sat : sat;
    endfunction

    function automatic logic signed [COORD_W-1:0] round_z(input logic signed [32:0] v);
        logic signed [33:0] ve;
        logic [33:0]        mag;
        logic [16:0]        q;
        ve  = 34'(v);
        mag = ve[33] ? 34'(-ve) : 34'(ve);
        q   = 17'((mag + 34'd16384) >> 15);
        return v[32] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [COORD_W-1:0] round_xy(input logic signed [48:0] v);
        logic signed [49:0] ve;
        logic [49:0]        mag;
        logic [16:0]        q;
        ve  = 50'(v);
        mag = ve[49] ? 50'(-ve) : 50'(ve);
        q   = 17'((mag + 50'd536870912) >> 30);
        return v[48] ? -$signed(q) : $signed(q);
    endfunction

endpackage

[hw/rtl/lrpc_if.sv]
// stream interfaces for range samples and converted points
interface lrpc_in_if;
    logic                             valid;
    logic                             ready;
    logic [lrpc_pkg::RANGE_W-1:0]     range;
    logic [lrpc_pkg::COLUMN_W-1:0]    column;
    logic [lrpc_pkg::ROW_W-1:0]       row;
    logic                             scan_end;

    modport source (output valid, range, column, row, scan_end, input ready);
    modport sink   (input valid, range, column, row, scan_end, output ready);
endinterface

interface lrpc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [lrpc_pkg::COORD_W-1:0]  x_pos;
    logic signed [lrpc_pkg::COORD_W-1:0]  y_pos;
    logic signed [lrpc_pkg::COORD_W-1:0]  z_pos;
    logic                                 kept;
    logic                                 last_point;

    modport source (output valid, x_pos, y_pos, z_pos, kept, last_point, input ready);
    modport sink   (input valid, x_pos, y_pos, z_pos, kept, last_point, output ready);
endinterface

[hw/rtl/lrpc_cordic.sv]
// pipelined rotation-mode cordic giving sine and cosine of a binary angle
module lrpc_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [lrpc_pkg::ANGLE_W-1:0]         i_angle,
    output logic signed [lrpc_pkg::TRIG_W-1:0]   o_sin,
    output logic signed [lrpc_pkg::TRIG_W-1:0]   o_cos
);

    lrpc_pkg::t_cordic_vec r_vec  [lrpc_pkg::CORDIC_PAIRS+1];
    logic                  r_flip [lrpc_pkg::CORDIC_PAIRS+1];
    logic signed [lrpc_pkg::TRIG_W-1:0] r_sin;
    logic signed [lrpc_pkg::TRIG_W-1:0] r_cos;

    logic [lrpc_pkg::ANGLE_W-1:0] quad;
    logic                         flip;
    logic [lrpc_pkg::ANGLE_W-1:0] folded;
    lrpc_pkg::t_cordic_vec        n_vec0;

    // fold into the right half plane
    always_comb begin
        quad     = i_angle + 16'h4000;
        flip     = quad[lrpc_pkg::ANGLE_W-1];
        folded   = flip ? i_angle + 16'h8000 : i_angle;
        n_vec0.x = lrpc_pkg::CORDIC_X0;
        n_vec0.y = '0;
        n_vec0.z = {folded[lrpc_pkg::ANGLE_W-1], folded, 16'h0000};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec[0]  <= n_vec0;
            r_flip[0] <= flip;
        end
    end

    for (genvar j = 0; j < lrpc_pkg::CORDIC_PAIRS; j++) begin : g_pair
        lrpc_pkg::t_cordic_vec mid;
        lrpc_pkg::t_cordic_vec n_vec;
        always_comb begin
            mid   = lrpc_pkg::cordic_rotate(r_vec[j], 4'(2*j));
            n_vec = lrpc_pkg::cordic_rotate(mid, 4'(2*j+1));
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_vec[j+1]  <= n_vec;
                r_flip[j+1] <= r_flip[j];
            end
        end
    end

    logic signed [lrpc_pkg::TRIG_W-1:0] n_sin;
    logic signed [lrpc_pkg::TRIG_W-1:0] n_cos;

    always_comb begin
        n_cos = lrpc_pkg::round_trig(r_vec[lrpc_pkg::CORDIC_PAIRS].x);
        n_sin = lrpc_pkg::round_trig(r_vec[lrpc_pkg::CORDIC_PAIRS].y);
        if (r_flip[lrpc_pkg::CORDIC_PAIRS]) begin
            n_cos = -n_cos;
            n_sin = -n_sin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

[hw/rtl/lidar_range_to_point_converter.sv]
// top level: lidar range sample to cartesian point converter
//
//   port    dir  kind             transaction
//   psel..  in   apb register     write at access phase, pready tied high
//   i_in    in   valid/ready      range, column, row, scan_end
//   o_out   out  valid/ready      x_pos, y_pos, z_pos, kept, last_point
//
// one sample a cycle while the output is not stalled; the result is registered
// through the angle stage, the cordic (input, 8 two-step stages, rounding),
// the two multiply stages and the result stage
// the whole pipeline advances together, holding while a full result stage is not taken
// synchronous active-low reset empties the pipeline and loads register defaults
module lidar_range_to_point_converter #(
    parameter int ROWS    = 64,
    parameter int COLUMNS = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lrpc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lrpc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lrpc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    lrpc_in_if.sink                            i_in,
    lrpc_out_if.source                         o_out
);

    localparam int LAT = lrpc_pkg::CORDIC_LAT;

    // configuration registers
    logic [15:0] r_range_lo;
    logic [15:0] r_range_hi;
    logic [15:0] r_yaw_start;
    logic [15:0] r_yaw_step;
    logic [15:0] r_pitch_start;
    logic [15:0] r_pitch_step;
    logic [lrpc_pkg::MASK_W-1:0] r_row_mask;

    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_lo    <= 16'd0;
            r_range_hi    <= 16'd65535;
            r_yaw_start   <= 16'd0;
            r_yaw_step    <= 16'd16;
            r_pitch_start <= 16'd0;
            r_pitch_step  <= 16'd256;
            r_row_mask    <= '1;
        end else if (wr_en) begin
            unique case (reg_idx)
                lrpc_pkg::REG_RANGE_LO:    r_range_lo    <= pwdata[15:0];
                lrpc_pkg::REG_RANGE_HI:    r_range_hi    <= pwdata[15:0];
                lrpc_pkg::REG_YAW_START:   r_yaw_start   <= pwdata[15:0];
                lrpc_pkg::REG_YAW_STEP:    r_yaw_step    <= pwdata[15:0];
                lrpc_pkg::REG_PITCH_START: r_pitch_start <= pwdata[15:0];
                lrpc_pkg::REG_PITCH_STEP:  r_pitch_step  <= pwdata[15:0];
                lrpc_pkg::REG_ROW_MASK:    r_row_mask    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            lrpc_pkg::REG_RANGE_LO:    prdata = 64'(r_range_lo);
            lrpc_pkg::REG_RANGE_HI:    prdata = 64'(r_range_hi);
            lrpc_pkg::REG_YAW_START:   prdata = 64'(r_yaw_start);
            lrpc_pkg::REG_YAW_STEP:    prdata = 64'(r_yaw_step);
            lrpc_pkg::REG_PITCH_START: prdata = 64'(r_pitch_start);
            lrpc_pkg::REG_PITCH_STEP:  prdata = 64'(r_pitch_step);
            lrpc_pkg::REG_ROW_MASK:    prdata = r_row_mask;
            default:                   prdata = '0;
        endcase
    end

    // pipeline advance
    logic r_o_valid;
    logic en;

    assign en         = !r_o_valid || o_out.ready;
    assign i_in.ready = en;

    // stage a: angles and gating
    logic        r_a_valid;
    logic [15:0] r_a_range;
    logic        r_a_kept;
    logic        r_a_last;
    logic [15:0] r_a_yaw;
    logic [15:0] r_a_pitch;

    logic [27:0] yaw_prod;
    logic [21:0] pitch_prod;
    logic        row_ok;
    logic        col_ok;
    logic        n_a_kept;

    always_comb begin
        yaw_prod   = 28'(i_in.column) * 28'(r_yaw_step);
        pitch_prod = 22'(i_in.row) * 22'(r_pitch_step);
        row_ok     = {1'b0, i_in.row} < 7'(ROWS);
        col_ok     = {5'b0, i_in.column} < 17'(COLUMNS);
        n_a_kept   = row_ok && col_ok && r_row_mask[i_in.row] &&
                     (r_range_lo < i_in.range) && (i_in.range < r_range_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_range <= i_in.range;
            r_a_kept  <= n_a_kept;
            r_a_last  <= i_in.scan_end;
            r_a_yaw   <= r_yaw_start + yaw_prod[15:0];
            r_a_pitch <= r_pitch_start + pitch_prod[15:0];
        end
    end

    // trig units
    logic signed [15:0] sin_y;
    logic signed [15:0] cos_y;
    logic signed [15:0] sin_p;
    logic signed [15:0] cos_p;

    lrpc_cordic u_cordic_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (r_a_yaw),
        .o_sin   (sin_y),
        .o_cos   (cos_y)
    );

    lrpc_cordic u_cordic_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (r_a_pitch),
        .o_sin   (sin_p),
        .o_cos   (cos_p)
    );

    // sideband alongside the trig units
    logic        r_sb_valid [LAT];
    logic [15:0] r_sb_range [LAT];
    logic        r_sb_kept  [LAT];
    logic        r_sb_last  [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) r_sb_valid[i] <= 1'b0;
        end else if (en) begin
            r_sb_valid[0] <= r_a_valid;
            for (int i = 1; i < LAT; i++) r_sb_valid[i] <= r_sb_valid[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb_range[0] <= r_a_range;
            r_sb_kept[0]  <= r_a_kept;
            r_sb_last[0]  <= r_a_last;
            for (int i = 1; i < LAT; i++) begin
                r_sb_range[i] <= r_sb_range[i-1];
                r_sb_kept[i]  <= r_sb_kept[i-1];
                r_sb_last[i]  <= r_sb_last[i-1];
            end
        end
    end

    // stage m: range times pitch terms
    logic               r_m_valid;
    logic               r_m_kept;
    logic               r_m_last;
    logic signed [32:0] r_m_rc;
    logic signed [32:0] r_m_rs;
    logic signed [15:0] r_m_cy;
    logic signed [15:0] r_m_sy;

    logic signed [16:0] range_s;
    logic signed [32:0] n_m_rc;
    logic signed [32:0] n_m_rs;

    always_comb begin
        range_s = $signed({1'b0, r_sb_range[LAT-1]});
        n_m_rc  = range_s * cos_p;
        n_m_rs  = range_s * sin_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= r_sb_valid[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_kept <= r_sb_kept[LAT-1];
            r_m_last <= r_sb_last[LAT-1];
            r_m_rc   <= n_m_rc;
            r_m_rs   <= n_m_rs;
            r_m_cy   <= cos_y;
            r_m_sy   <= sin_y;
        end
    end

    // stage p: yaw products and z rounding
    logic               r_p_valid;
    logic               r_p_kept;
    logic               r_p_last;
    logic signed [48:0] r_p_xprod;
    logic signed [48:0] r_p_yprod;
    logic signed [16:0] r_p_z;

    logic signed [48:0] n_p_xprod;
    logic signed [48:0] n_p_yprod;

    always_comb begin
        n_p_xprod = r_m_rc * r_m_cy;
        n_p_yprod = r_m_rc * r_m_sy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_kept  <= r_m_kept;
            r_p_last  <= r_m_last;
            r_p_xprod <= n_p_xprod;
            r_p_yprod <= n_p_yprod;
            r_p_z     <= lrpc_pkg::round_z(r_m_rs);
        end
    end

    // result stage
    logic signed [16:0] r_o_x;
    logic signed [16:0] r_o_y;
    logic signed [16:0] r_o_z;
    logic               r_o_kept;
    logic               r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_x    <= r_p_kept ? lrpc_pkg::round_xy(r_p_xprod) : '0;
            r_o_y    <= r_p_kept ? lrpc_pkg::round_xy(r_p_yprod) : '0;
            r_o_z    <= r_p_kept ? r_p_z : '0;
            r_o_kept <= r_p_kept;
            r_o_last <= r_p_last;
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.x_pos      = r_o_x;
    assign o_out.y_pos      = r_o_y;
    assign o_out.z_pos      = r_o_z;
    assign o_out.kept       = r_o_kept;
    assign o_out.last_point = r_o_last;

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.kept |->
            o_out.x_pos == '0 && o_out.y_pos == '0 && o_out.z_pos == '0)
        else $error("rejected point carries nonzero coordinates");

    a_coord_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.x_pos != 17'h10000 && o_out.y_pos != 17'h10000 &&
            o_out.z_pos != 17'h10000)
        else $error("coordinate outside rounded range");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out.valid && !r_m_valid && !r_p_valid)
        else $error("pipeline not empty after reset");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_p_valid) && $stable(r_m_valid) && $stable(r_a_valid))
        else $error("pipeline moved during stall");

endmodule
